// ===== rtl/bitmap_frame_allocator_assert.svh =====
// Assertion macros for the bitmap frame allocator.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap_frame_allocator assertion failed");

// next-cycle implication
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap_frame_allocator assertion failed");

`endif

// ===== rtl/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
// No dependencies.
package bfa_pkg;

    localparam int BFA_NUM_FRAMES = 4096;
    localparam int BFA_WORD_BITS  = 32;
    localparam int PAGE_FRAME_W   = 12;
    localparam int STATUS_W       = 3;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ALLOC = 3'd0,
        STAT_HELD  = 3'd1,
        STAT_FULL  = 3'd2,
        STAT_FREED = 3'd3,
        STAT_NONE  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t                 status;
        logic [PAGE_FRAME_W-1:0] new_frame;
        logic                    present_bit;
        logic                    rw_bit;
        logic                    user_bit;
    } bfa_rsp_t;

endpackage

// ===== rtl/bfa_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on bfa_pkg.
interface bfa_req_if import bfa_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [PAGE_FRAME_W-1:0] page_frame;
    logic                    kernel_page;
    logic                    writable_page;

    modport source (output valid, func, page_frame, kernel_page, writable_page,
                    input ready);
    modport sink   (input valid, func, page_frame, kernel_page, writable_page,
                    output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [PAGE_FRAME_W-1:0] new_frame;
    logic                    present_bit;
    logic                    rw_bit;
    logic                    user_bit;

    modport source (output valid, status, new_frame, present_bit, rw_bit, user_bit,
                    input ready);
    modport sink   (input valid, status, new_frame, present_bit, rw_bit, user_bit,
                    output ready);
endinterface

// ===== rtl/bfa_bitmap_ram.sv =====
// Frame bitmap storage: one write port, one read port, registered read data.
// No dependencies.
module bfa_bitmap_ram #(
    parameter  int DEPTH  = 128,
    parameter  int WIDTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bfa_ctrl.sv =====
// Allocator sequencer: clear pass, word scan, free read-modify-write, output register.
// Depends on bfa_pkg, bfa_if.
module bfa_ctrl import bfa_pkg::*; #(
    parameter  int NUM_FRAMES = BFA_NUM_FRAMES,
    parameter  int WORD_BITS  = BFA_WORD_BITS,
    localparam int NWORDS     = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS,
    localparam int ADDR_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    bfa_req_if.sink            req,
    bfa_rsp_if.source          rsp,
    output logic               ram_wr_en,
    output logic [ADDR_W-1:0]  ram_wr_addr,
    output logic [WORD_BITS-1:0] ram_wr_data,
    output logic [ADDR_W-1:0]  ram_rd_addr,
    input  logic [WORD_BITS-1:0] ram_rd_data
);

    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int BASE_W      = $clog2(NWORDS * WORD_BITS);
    localparam int LAST_BITS   = NUM_FRAMES - (NWORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NWORDS - 1);
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W      = PAGE_FRAME_W + RECIP_SHIFT - 2;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [BASE_W-1:0]       base_reg, base_next;
    logic [PAGE_FRAME_W-1:0] pf_reg, pf_next;
    logic                    kern_reg, kern_next;
    logic                    wr_reg, wr_next;
    bfa_rsp_t                res_reg, res_next;
    bfa_rsp_t                out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic [PROD_W-1:0]       recip_prod;
    logic [QUOT_W-1:0]       req_word;
    logic [WORD_BITS-1:0]    word_free;
    logic [WORD_BITS-1:0]    lowest_free;
    logic [BIT_W-1:0]        free_bit;
    logic [BASE_W-1:0]       found_frame;
    logic [PAGE_FRAME_W-1:0] free_rem;
    logic [WORD_BITS-1:0]    clr_mask;
    logic                    out_load;

    // word index of the frame to free: reciprocal multiply, exact for 12-bit frames
    assign recip_prod = PROD_W'(req.page_frame) * PROD_W'(RECIP);
    assign req_word   = recip_prod[PROD_W-1:RECIP_SHIFT];

    // frames past the end of the bitmap count as used
    assign word_free   = ~ram_rd_data & ((addr_reg == LAST_ADDR) ? LAST_MASK : '1);
    assign lowest_free = word_free & (~word_free + WORD_BITS'(1));
    assign found_frame = base_reg + BASE_W'(free_bit);

    always_comb
    begin
        free_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (word_free[i])
            begin
                free_bit = BIT_W'(i);
            end
        end
    end

    assign free_rem = pf_reg - PAGE_FRAME_W'(addr_reg * BASE_W'(WORD_BITS));
    assign clr_mask = WORD_BITS'(1) << free_rem[BIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        pf_reg   <= pf_next;
        kern_reg <= kern_next;
        wr_reg   <= wr_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        base_next   = base_reg;
        pf_next     = pf_reg;
        kern_next   = kern_reg;
        wr_next     = wr_reg;
        res_next    = res_reg;
        req.ready   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_reg;
        ram_wr_data = '0;
        ram_rd_addr = addr_reg;
        out_load    = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    pf_next   = req.page_frame;
                    kern_next = req.kernel_page;
                    wr_next   = req.writable_page;
                    res_next  = '{status: STAT_HELD, new_frame: req.page_frame,
                                  present_bit: 1'b0, rw_bit: 1'b0, user_bit: 1'b0};
                    if (req.func == FN_ALLOC)
                    begin
                        if (req.page_frame != '0)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            ram_rd_addr = '0;
                            addr_next   = '0;
                            base_next   = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    else if (req.page_frame == '0 ||
                             32'(req.page_frame) >= 32'(NUM_FRAMES))
                    begin
                        res_next.status = STAT_NONE;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        ram_rd_addr = ADDR_W'(req_word);
                        addr_next   = ADDR_W'(req_word);
                        state_next  = S_FREE;
                    end
                end
            end
            S_SCAN:
            begin
                if (word_free != '0)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data | lowest_free;
                    res_next    = '{status: STAT_ALLOC,
                                    new_frame: PAGE_FRAME_W'(found_frame),
                                    present_bit: 1'b1, rw_bit: wr_reg,
                                    user_bit: ~kern_reg};
                    state_next  = S_RESP;
                end
                else if (addr_reg == LAST_ADDR)
                begin
                    res_next   = '{status: STAT_FULL, new_frame: '0,
                                   present_bit: 1'b0, rw_bit: 1'b0, user_bit: 1'b0};
                    state_next = S_RESP;
                end
                else
                begin
                    addr_next   = addr_reg + ADDR_W'(1);
                    ram_rd_addr = addr_reg + ADDR_W'(1);
                    base_next   = base_reg + BASE_W'(WORD_BITS);
                end
            end
            S_FREE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data & ~clr_mask;
                res_next    = '{status: STAT_FREED, new_frame: '0,
                                present_bit: 1'b0, rw_bit: 1'b0, user_bit: 1'b0};
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_load ? res_reg : out_reg;
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !rsp.ready);
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.new_frame   = out_reg.new_frame;
    assign rsp.present_bit = out_reg.present_bit;
    assign rsp.rw_bit      = out_reg.rw_bit;
    assign rsp.user_bit    = out_reg.user_bit;

endmodule

// ===== rtl/bitmap_frame_allocator.sv =====
// Bitmap frame allocator, top level. Held and nothing-to-free requests go straight to
// the response state; a free of a valid frame first passes the read-modify-write state.
// Allocate scans from bitmap word 0 until a free frame or the last word, one bitmap word read per cycle.
// One transaction at a time: ready returns high only as the result turns valid.
// After reset a clearing pass writes NWORDS words (128 at defaults), ready held low.
// Depends on bfa_pkg, bfa_if, bfa_bitmap_ram, bfa_ctrl, bitmap_frame_allocator_assert.svh.
module bitmap_frame_allocator import bfa_pkg::*; #(
    parameter int NUM_FRAMES = BFA_NUM_FRAMES,
    parameter int WORD_BITS  = BFA_WORD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    bfa_req_if.sink   req,
    bfa_rsp_if.source rsp
);

    localparam int NWORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;

    bfa_ctrl #(
        .NUM_FRAMES (NUM_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    bfa_bitmap_ram #(
        .DEPTH (NWORDS),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

`include "bitmap_frame_allocator_assert.svh"

    `BFA_ASSERT_IMPL(a_no_write_when_ready, req.ready, !ram_wr_en)
    `BFA_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)
    `BFA_ASSERT_IMPL(a_flags_only_on_alloc, rsp.valid && rsp.status != STAT_ALLOC,
                     !rsp.present_bit && !rsp.rw_bit && !rsp.user_bit)

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for bitmap_frame_allocator: directed, fill and random traffic.
// Uses bfa_pkg, the bfa_req_if / bfa_rsp_if channels and the allocator RTL; nothing else.
module tb;
    import bfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWORDS       = (BFA_NUM_FRAMES + BFA_WORD_BITS - 1) / BFA_WORD_BITS;
    localparam int FILL_OPS     = 1000;
    localparam int RANDOM_OPS   = 530;
    localparam int PHASE_LEN    = 150;
    localparam int TAIL_CYCLES  = 3 * (NWORDS + 2);
    localparam int CYCLE_LIMIT  = 3000000;

    typedef enum logic [1:0] {
        PACE_FULL_RATE,
        PACE_SLOW_SEND,
        PACE_SLOW_RECV,
        PACE_BOTH_JITTER
    } pace_t;

    typedef struct {
        logic                    func;
        logic [PAGE_FRAME_W-1:0] page_frame;
        logic                    kernel_page;
        logic                    writable_page;
        pace_t                   pace;
        bit                      wait_drain;
    } frame_op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();

    bitmap_frame_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    frame_op_t  frame_op_q[$];
    bfa_rsp_t   alloc_results_q[$];
    logic [BFA_WORD_BITS-1:0] frame_map [NWORDS];
    pace_t      recv_pace;
    int         op_count;
    int         mismatches;
    int         cycle_cnt;
    int         status_seen [5];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bfa_rsp_t frame_alloc_outcome(input frame_op_t op);
        bfa_rsp_t r;
        int       f;
        r = '0;
        f = -1;
        if (op.func == FN_ALLOC)
        begin
            if (op.page_frame != 0)
            begin
                r.status    = STAT_HELD;
                r.new_frame = op.page_frame;
            end
            else
            begin
                for (int w = 0; w < NWORDS && f < 0; w++)
                    for (int b = 0; b < BFA_WORD_BITS && f < 0; b++)
                        if (!frame_map[w][b] && (w * BFA_WORD_BITS + b) < BFA_NUM_FRAMES)
                            f = w * BFA_WORD_BITS + b;
                if (f >= 0)
                begin
                    frame_map[f / BFA_WORD_BITS][f % BFA_WORD_BITS] = 1'b1;
                    r.status      = STAT_ALLOC;
                    r.new_frame   = f[PAGE_FRAME_W-1:0];
                    r.present_bit = 1'b1;
                    r.rw_bit      = op.writable_page;
                    r.user_bit    = !op.kernel_page;
                end
                else
                    r.status = STAT_FULL;
            end
        end
        else
        begin
            if (op.page_frame == 0 || int'(op.page_frame) >= BFA_NUM_FRAMES)
            begin
                r.status    = STAT_NONE;
                r.new_frame = op.page_frame;
            end
            else
            begin
                frame_map[op.page_frame / BFA_WORD_BITS][op.page_frame % BFA_WORD_BITS] = 1'b0;
                r.status = STAT_FREED;
            end
        end
        return r;
    endfunction

    function automatic bit field_ok(input string name, input int want, input int got);
        if (want != got)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return want == got;
    endfunction

    task automatic queue_op(input logic func, input int pf, input bit wait_drain = 0);
        frame_op_t op;
        op.func          = func;
        op.page_frame    = pf[PAGE_FRAME_W-1:0];
        op.kernel_page   = $urandom_range(1);
        op.writable_page = $urandom_range(1);
        op.pace          = pace_t'((op_count / PHASE_LEN) % 4);
        op.wait_drain    = wait_drain;
        frame_op_q.push_back(op);
        op_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        frame_op_t op;
        bit        send;
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.func          <= FN_ALLOC;
            req_ch.page_frame    <= '0;
            req_ch.kernel_page   <= 1'b0;
            req_ch.writable_page <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                alloc_results_q.push_back(frame_alloc_outcome(frame_op_q[0]));
                recv_pace <= frame_op_q[0].pace;
                void'(frame_op_q.pop_front());
            end
            send = 0;
            op   = '{FN_ALLOC, '0, 1'b0, 1'b0, PACE_FULL_RATE, 0};
            if (frame_op_q.size() > 0)
            begin
                op = frame_op_q[0];
                if (req_ch.valid && !req_ch.ready)
                    send = 1;
                else if (op.wait_drain && alloc_results_q.size() > 0)
                    send = 0;
                else if (op.pace == PACE_SLOW_SEND)
                    send = $urandom_range(99) >= 88;
                else if (op.pace == PACE_BOTH_JITTER)
                    send = $urandom_range(99) >= 16;
                else
                    send = 1;
            end
            req_ch.valid         <= send;
            req_ch.func          <= op.func;
            req_ch.page_frame    <= op.page_frame;
            req_ch.kernel_page   <= op.kernel_page;
            req_ch.writable_page <= op.writable_page;
        end
    end

    // monitor and scoreboard
    always @(posedge clk or negedge rst_n)
    begin
        bfa_rsp_t want;
        bit       ok;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_ch.status < 5)
                    status_seen[rsp_ch.status]++;
                if (alloc_results_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, status %0d frame %0d", $time,
                             rsp_ch.status, rsp_ch.new_frame);
                    mismatches++;
                end
                else
                begin
                    want = alloc_results_q.pop_front();
                    ok = field_ok("status", want.status, rsp_ch.status);
                    ok = field_ok("new_frame", want.new_frame, rsp_ch.new_frame) && ok;
                    ok = field_ok("present_bit", want.present_bit, rsp_ch.present_bit) && ok;
                    ok = field_ok("rw_bit", want.rw_bit, rsp_ch.rw_bit) && ok;
                    ok = field_ok("user_bit", want.user_bit, rsp_ch.user_bit) && ok;
                    if (!ok)
                        mismatches++;
                end
            end
            case (recv_pace)
                PACE_SLOW_RECV:   rsp_ch.ready <= $urandom_range(99) >= 88;
                PACE_BOTH_JITTER: rsp_ch.ready <= $urandom_range(99) >= 16;
                default:          rsp_ch.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d transactions still expected", $time,
                     alloc_results_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int pick;
        req_ch.valid         = 1'b0;
        req_ch.func          = FN_ALLOC;
        req_ch.page_frame    = '0;
        req_ch.kernel_page   = 1'b0;
        req_ch.writable_page = 1'b0;
        rsp_ch.ready         = 1'b0;
        recv_pace            = PACE_FULL_RATE;
        foreach (frame_map[w])
            frame_map[w] = '0;

        // directed: frame zero, held entries, empty and repeated frees
        queue_op(FN_ALLOC, 0);
        queue_op(FN_ALLOC, 0);
        queue_op(FN_ALLOC, 0);
        queue_op(FN_ALLOC, 0);
        queue_op(FN_ALLOC, 4095);
        queue_op(FN_ALLOC, 'hAAA);
        queue_op(FN_ALLOC, 'h555);
        queue_op(FN_ALLOC, 1);
        queue_op(FN_FREE, 0);
        queue_op(FN_FREE, 2);
        queue_op(FN_FREE, 2);
        queue_op(FN_FREE, 4095);
        queue_op(FN_ALLOC, 0);
        queue_op(FN_FREE, 'hAAA);
        queue_op(FN_FREE, 'h555);
        queue_op(FN_FREE, 1);
        queue_op(FN_FREE, 3);
        queue_op(FN_ALLOC, 0);
        queue_op(FN_ALLOC, 0);
        queue_op(FN_ALLOC, 'hFFF);

        // fill the low part of the map, scans grow across many words
        queue_op(FN_ALLOC, 0, 1);
        for (int i = 1; i < FILL_OPS; i++)
            queue_op(FN_ALLOC, 0);

        // random churn around the filled region
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                queue_op(FN_FREE, $urandom_range(FILL_OPS + 63, 1), i % 400 == 0);
            else if (pick < 85)
                queue_op(FN_ALLOC, 0, i % 400 == 0);
            else if (pick < 95)
                queue_op(FN_ALLOC, $urandom_range(4095, 1), i % 400 == 0);
            else
                queue_op(FN_FREE, 0, i % 400 == 0);
        end

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (frame_op_q.size() != 0 || alloc_results_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (alloc_results_q.size() != 0)
        begin
            $display("%0t: %0d transactions never arrived", $time, alloc_results_q.size());
            mismatches++;
        end

        $display("Covered %0d requests: %0d allocated, %0d held, %0d full,", op_count,
                 status_seen[STAT_ALLOC], status_seen[STAT_HELD], status_seen[STAT_FULL]);
        $display("  %0d freed, %0d nothing to free; %0d mismatches", status_seen[STAT_FREED],
                 status_seen[STAT_NONE], mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
